// File: rtl/core/tpc_pkg.sv
// Package for the text to prefix code decoder: payload and job types,
// the character classifier and the fixed codeword table.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package tpc_pkg;

	// Depth of the job queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Item operations.
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOL  = 1'b1;

	// Longest codeword and the symbol width.
	localparam int unsigned MAX_CODE_LEN = 8;
	localparam int unsigned SYM_W        = 5;

	typedef struct packed {
		logic       op;
		logic [7:0] char_in;
	} in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       line_end;
		logic       last;
	} out_t;

	// One queued job: a line end, or one or two decoded characters.
	typedef struct packed {
		logic       line_end;
		logic       two;
		logic [7:0] ch0;
		logic [7:0] ch1;
	} job_t;

	// Maps a byte to its 5-bit symbol; bit 5 is set when the byte is mapped.
	function automatic logic [5:0] sym_of(input logic [7:0] c);
		logic [5:0] r;
		r = '0;
		case (c) inside
			[8'h41:8'h5A]: r = {1'b1, 5'(c - 8'h41)};
			8'h20:         r = {1'b1, 5'd26};
			8'h2E:         r = {1'b1, 5'd27};
			8'h2C:         r = {1'b1, 5'd28};
			8'h2D:         r = {1'b1, 5'd29};
			8'h27:         r = {1'b1, 5'd30};
			8'h3F:         r = {1'b1, 5'd31};
			default:       r = '0;
		endcase
		return r;
	endfunction

	// Looks up a codeword of the given length; zero means no match.
	function automatic logic [7:0] match_code(input logic [3:0] len, input logic [7:0] bits);
		logic [7:0] ch;
		ch = '0;
		case ({len, bits})
			{4'd3, 8'h05}: ch = 8'h20;
			{4'd3, 8'h06}: ch = "E";
			{4'd3, 8'h07}: ch = "P";
			{4'd4, 8'h01}: ch = "D";
			{4'd4, 8'h05}: ch = "C";
			{4'd4, 8'h06}: ch = "K";
			{4'd4, 8'h07}: ch = "I";
			{4'd4, 8'h08}: ch = "R";
			{4'd5, 8'h04}: ch = "L";
			{4'd5, 8'h05}: ch = "O";
			{4'd5, 8'h06}: ch = "S";
			{4'd5, 8'h07}: ch = "T";
			{4'd5, 8'h09}: ch = "F";
			{4'd6, 8'h00}: ch = 8'h27;
			{4'd6, 8'h01}: ch = "?";
			{4'd6, 8'h02}: ch = "W";
			{4'd6, 8'h03}: ch = ",";
			{4'd6, 8'h10}: ch = "H";
			{4'd6, 8'h11}: ch = ".";
			{4'd6, 8'h25}: ch = "A";
			{4'd8, 8'h90}: ch = "Z";
			{4'd8, 8'h91}: ch = "-";
			{4'd8, 8'h92}: ch = "X";
			{4'd8, 8'h93}: ch = "Y";
			{4'd8, 8'h98}: ch = "J";
			{4'd8, 8'h99}: ch = "M";
			{4'd8, 8'h9A}: ch = "B";
			{4'd8, 8'h9B}: ch = "G";
			{4'd8, 8'h9C}: ch = "U";
			{4'd8, 8'h9D}: ch = "V";
			{4'd8, 8'h9E}: ch = "N";
			{4'd8, 8'h9F}: ch = "Q";
			default:       ch = '0;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/core/tpc_front.sv
// Front part: accepts items, decodes symbol bits against the pending
// codeword, pushes a job on a match or line end. Depends on tpc_pkg.
`timescale 1ns / 1ps

module tpc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tpc_pkg::in_t  in_data,
	input  logic          q_full,
	output logic          push,
	output tpc_pkg::job_t push_job
);

	logic [6:0] pb_q;
	logic [2:0] cnt_q;
	logic [6:0] pb;
	logic [2:0] cnt;
	logic [1:0] n;
	logic [7:0] ch0;
	logic [7:0] ch1;
	logic [7:0] ch;
	logic [3:0] len;
	logic [7:0] bits;
	logic [5:0] sym;
	logic       accept;

	assign sym = tpc_pkg::sym_of(in_data.char_in);

	// Walk the five symbol bits, most significant first.
	always_comb begin
		pb  = pb_q;
		cnt = cnt_q;
		n   = '0;
		ch0 = '0;
		ch1 = '0;
		len = '0;
		bits = '0;
		ch  = '0;
		for (int b = tpc_pkg::SYM_W - 1; b >= 0; b--) begin
			len  = {1'b0, cnt} + 4'd1;
			bits = {pb, sym[3'(b)]};
			ch   = tpc_pkg::match_code(len, bits);
			if (ch != '0) begin
				if (n == 2'd0) begin
					ch0 = ch;
				end else begin
					ch1 = ch;
				end
				n   = n + 2'd1;
				pb  = '0;
				cnt = '0;
			end else if (len >= 4'(tpc_pkg::MAX_CODE_LEN)) begin
				pb  = '0;
				cnt = '0;
			end else begin
				pb  = bits[6:0];
				cnt = len[2:0];
			end
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign push = accept && ((in_data.op == tpc_pkg::OP_EOL) || (sym[5] && (n != 2'd0)));

	always_comb begin
		push_job.line_end = (in_data.op == tpc_pkg::OP_EOL);
		push_job.two      = (n == 2'd2);
		push_job.ch0      = ch0;
		push_job.ch1      = ch1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (in_data.op == tpc_pkg::OP_EOL) begin
				pb_q  <= '0;
				cnt_q <= '0;
			end else if (sym[5]) begin
				pb_q  <= pb;
				cnt_q <= cnt;
			end
		end
	end

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.op == tpc_pkg::OP_EOL) |=> (cnt_q == '0 && pb_q == '0))
		else $error("Pending bits survived a line end.");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("Job pushed into a full queue.");

endmodule

// File: rtl/core/tpc_queue.sv
// Short job queue between the front and back parts.
// Depends on tpc_pkg for the job type.
`timescale 1ns / 1ps

module tpc_queue #(
	parameter int unsigned DEPTH = tpc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tpc_pkg::job_t head_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tpc_pkg::job_t      slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Queue count beyond depth.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("Pop from an empty queue.");

endmodule

// File: rtl/core/tpc_back.sv
// Back part: takes jobs from the queue and, while out_ready is high,
// gives one result per cycle through a register. Depends on tpc_pkg.
`timescale 1ns / 1ps

module tpc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  tpc_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output tpc_pkg::out_t out_data
);

	tpc_pkg::out_t out_q;
	logic          out_valid_q;
	logic          idx_q;
	logic          load;
	logic          first_of_two;

	assign load         = !out_valid_q || out_ready;
	assign first_of_two = head_job.two && !head_job.line_end && !idx_q;
	assign pop          = load && head_valid && !first_of_two;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			if (head_job.line_end) begin
				out_q <= '{char_out: 8'h00, line_end: 1'b1, last: 1'b1};
			end else if (first_of_two) begin
				out_q <= '{char_out: head_job.ch0, line_end: 1'b0, last: 1'b0};
			end else begin
				out_q <= '{char_out: (head_job.two ? head_job.ch1 : head_job.ch0),
					line_end: 1'b0, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= first_of_two;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_second_pending: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (out_valid_q && !out_q.last && !out_q.line_end))
		else $error("Second codeword pending without a first result shown.");

endmodule

// File: rtl/core/text_to_prefix_code_decoder.sv
// Path: an item's result passes through the job queue and then the output register
// before it shows on out_valid.
// Throughput: one item per cycle while the job queue is not full; an item that
// completes two codewords gives two results, one per cycle while out_ready is high.
// Reset: arst_n clears pending codeword bits, the job queue and the output valid flag.
// Depends on tpc_pkg, tpc_front, tpc_queue and tpc_back.
`timescale 1ns / 1ps

module text_to_prefix_code_decoder #(
	parameter int unsigned QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tpc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tpc_pkg::out_t out_data
);

	// The front maps each character to a 5-bit symbol and walks its bits
	// through the codeword table in the same cycle as the transfer, so the
	// pending codeword state is current for the very next item. Character items that
	// complete nothing leave no job behind.
	logic          push;
	tpc_pkg::job_t push_job;
	logic          q_full;

	// The queue lets the front keep taking items while the back is still
	// handing out a two-result job or the consumer stalls.
	logic          pop;
	logic          head_valid;
	tpc_pkg::job_t head_job;

	tpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	tpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// The back expands each job into one or two result transfers and marks
	// the final one with last.
	tpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
